/* rtl/cpjq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpjq_pkg
// shared constants, codes and types of the class priority job queue
// ----------------------------------------------------------------------------
package cpjq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int HANDLE_BITS = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int KIND_W      = 3;
    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 2;
    // kinds 0 to 4 are ranked by pop, each with its own counter
    localparam int NUM_CLASSES = 5;

    localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DROP4  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DRAIN4 = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DRAIN1 = 3'd4;

    localparam logic [KIND_W-1:0] KIND_MATCH  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UPSERT = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [HANDLE_BITS-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic accept;   // take the input word
        logic rd_en;    // read the entry at the read pointer
        logic emit;     // hand the fetched entry to the output register
        logic keep;     // write the fetched entry back at the write pointer
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;   // output register can take a word this cycle
        logic scan_req;   // the offered word removes entries
        logic hit;        // fetched entry is one to remove
        logic scan_done;  // fetched entry was the last one held
    } dp_stat_t;

endpackage

/* rtl/class_priority_job_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_priority_job_queue
// ordered job queue: push, class priority pop, drop and drain of one kind
// ----------------------------------------------------------------------------
// channel   dir  tdata                                   tuser                tlast
// s_axis    in   job_kind, job_handle                    action               -
// m_axis    out  out_kind, out_handle, fill_level        found, status        last
//
// push, and any action that removes nothing, leaves the sequencer idle; the next word
// can be taken in the following cycle while the output register has room.
// a removing action scans every held entry through the single memory port,
// reading and then checking each one in turn, compacting the survivors in place.
// output stalls hold the scan on the entry that waits to go out.
// reset clears the fill count, class counters, scan state and output valid; no clearing pass.
// ----------------------------------------------------------------------------
module class_priority_job_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // job_kind[2:0], job_handle[18:3], zero pad
    input  logic [2:0]  s_axis_tuser,   // action[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_kind[2:0], out_handle[18:3], fill_level[25:19]
    output logic [2:0]  m_axis_tuser,   // found[0], status[2:1]
    output logic        m_axis_tlast
);
    import cpjq_pkg::*;

    ctrl_cmd_t              cmd;
    dp_stat_t               stat;
    logic                   out_found;
    logic [KIND_W-1:0]      out_kind;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [STATUS_W-1:0]    out_status;
    logic [CNT_W-1:0]       out_fill;

    cpjq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cpjq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_action  (s_axis_tuser[ACTION_W-1:0]),
        .in_kind    (s_axis_tdata[KIND_W-1:0]),
        .in_handle  (s_axis_tdata[KIND_W+HANDLE_BITS-1:KIND_W]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_found  (out_found),
        .out_kind   (out_kind),
        .out_handle (out_handle),
        .out_status (out_status),
        .out_last   (m_axis_tlast),
        .out_fill   (out_fill)
    );

    assign m_axis_tdata = {6'd0, out_fill, out_handle, out_kind};
    assign m_axis_tuser = {out_status, out_found};

    // a word is only taken while the output register has room for its result
    a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
        else $error("input taken while output register is blocked");

    // only drained entries can be followed by more words of the same action
    a_nonlast_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser[0])
        else $error("non-final word carries no entry");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (m_axis_tvalid && m_axis_tuser[0]))
        else $error("removed entry did not reach the output");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_fill <= CNT_W'(QUEUE_DEPTH)))
        else $error("fill level beyond depth");

endmodule

/* rtl/cpjq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpjq_ctrl
// sequencer: accepts words and steps the read, compact and emit scan
// ----------------------------------------------------------------------------
module cpjq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cpjq_pkg::dp_stat_t   stat,
    output cpjq_pkg::ctrl_cmd_t  cmd
);
    import cpjq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    cmd.accept = 1'b1;
                    if (stat.scan_req)
                        state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.hit)
                begin
                    // a removed entry waits here while the output is stalled
                    if (stat.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = stat.scan_done ? S_IDLE : S_READ;
                    end
                end
                else
                begin
                    cmd.keep   = 1'b1;
                    state_next = stat.scan_done ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/cpjq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpjq_dp
// entry memory, class counters, scan pointers and output register
// ----------------------------------------------------------------------------
module cpjq_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cpjq_pkg::ctrl_cmd_t                   cmd,
    output cpjq_pkg::dp_stat_t                    stat,
    input  logic [cpjq_pkg::ACTION_W-1:0]         in_action,
    input  logic [cpjq_pkg::KIND_W-1:0]           in_kind,
    input  logic [cpjq_pkg::HANDLE_BITS-1:0]      in_handle,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic                                  out_found,
    output logic [cpjq_pkg::KIND_W-1:0]           out_kind,
    output logic [cpjq_pkg::HANDLE_BITS-1:0]      out_handle,
    output logic [cpjq_pkg::STATUS_W-1:0]         out_status,
    output logic                                  out_last,
    output logic [cpjq_pkg::CNT_W-1:0]            out_fill
);
    import cpjq_pkg::*;

    entry_t                mem [QUEUE_DEPTH];
    entry_t                rd_data_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      class_cnt_reg [NUM_CLASSES];
    logic [CNT_W-1:0]      rd_ptr_reg;
    logic [ADDR_W-1:0]     wr_ptr_reg;
    logic [CNT_W-1:0]      scan_end_reg;
    logic [CNT_W-1:0]      remain_reg;
    logic [KIND_W-1:0]     tgt_kind_reg;
    logic                  any_mode_reg;

    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [KIND_W-1:0]     out_kind_reg;
    logic [HANDLE_BITS-1:0] out_handle_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_last_reg;
    logic [CNT_W-1:0]      out_fill_reg;

    logic                  is_push;
    logic                  full;
    logic                  push_ok;
    logic                  found_cls;
    logic [KIND_W-1:0]     pop_kind;
    logic                  req_scan;
    logic                  req_any;
    logic [KIND_W-1:0]     req_kind;
    logic [CNT_W-1:0]      req_total;
    logic [STATUS_W-1:0]   req_status;
    logic                  out_load_now;

    assign is_push = (in_action == ACT_PUSH);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push_ok = cmd.accept && is_push && !full;

    // lowest ranked kind that is held
    always_comb
    begin
        found_cls = 1'b0;
        pop_kind  = '0;
        for (int k = NUM_CLASSES - 1; k >= 0; k--)
        begin
            if (class_cnt_reg[k] != '0)
            begin
                found_cls = 1'b1;
                pop_kind  = KIND_W'(k);
            end
        end
    end

    always_comb
    begin
        req_scan   = 1'b0;
        req_any    = 1'b0;
        req_kind   = pop_kind;
        req_total  = '0;
        req_status = ST_NONE;
        case (in_action)
            ACT_PUSH:
            begin
                req_status = full ? ST_FULL : ST_OK;
            end
            ACT_POP:
            begin
                if (found_cls)
                begin
                    req_scan  = 1'b1;
                    req_total = CNT_W'(1);
                end
                else if (count_reg != '0)
                begin
                    // only kinds 5 to 7 are held: take the head
                    req_scan  = 1'b1;
                    req_any   = 1'b1;
                    req_total = CNT_W'(1);
                end
            end
            ACT_DROP4:
            begin
                req_kind = KIND_UPSERT;
                if (class_cnt_reg[KIND_UPSERT] != '0)
                begin
                    req_scan  = 1'b1;
                    req_total = CNT_W'(1);
                end
            end
            ACT_DRAIN4:
            begin
                req_kind  = KIND_UPSERT;
                req_total = class_cnt_reg[KIND_UPSERT];
                req_scan  = (class_cnt_reg[KIND_UPSERT] != '0);
            end
            ACT_DRAIN1:
            begin
                req_kind  = KIND_MATCH;
                req_total = class_cnt_reg[KIND_MATCH];
                req_scan  = (class_cnt_reg[KIND_MATCH] != '0);
            end
            default:
            begin
                req_status = ST_NONE;
            end
        endcase
    end

    assign out_load_now = cmd.accept && !req_scan;

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.scan_req  = req_scan;
    assign stat.hit       = (remain_reg != '0)
                            && (any_mode_reg || (rd_data_reg.kind == tgt_kind_reg));
    assign stat.scan_done = (rd_ptr_reg == scan_end_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            for (int k = 0; k < NUM_CLASSES; k++)
                class_cnt_reg[k] <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            scan_end_reg  <= '0;
            remain_reg    <= '0;
            tgt_kind_reg  <= '0;
            any_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load_now || cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (push_ok)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (in_kind < KIND_W'(NUM_CLASSES))
                    class_cnt_reg[in_kind] <= class_cnt_reg[in_kind] + CNT_W'(1);
            end

            if (cmd.accept && req_scan)
            begin
                rd_ptr_reg   <= '0;
                wr_ptr_reg   <= '0;
                scan_end_reg <= count_reg;
                remain_reg   <= req_total;
                tgt_kind_reg <= req_kind;
                any_mode_reg <= req_any;
                // the new fill is known up front and goes out with every word
                count_reg    <= count_reg - req_total;
                if (!req_any)
                    class_cnt_reg[req_kind] <= class_cnt_reg[req_kind] - req_total;
            end

            if (cmd.rd_en)
                rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
            if (cmd.keep)
                wr_ptr_reg <= wr_ptr_reg + ADDR_W'(1);
            if (cmd.emit)
                remain_reg <= remain_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem[count_reg[ADDR_W-1:0]] <= '{kind: in_kind, handle: in_handle};
        else if (cmd.keep)
            mem[wr_ptr_reg] <= rd_data_reg;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_ptr_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (out_load_now)
        begin
            out_found_reg  <= 1'b0;
            out_kind_reg   <= '0;
            out_handle_reg <= '0;
            out_status_reg <= req_status;
            out_last_reg   <= 1'b1;
            out_fill_reg   <= push_ok ? count_reg + CNT_W'(1) : count_reg;
        end
        else if (cmd.emit)
        begin
            out_found_reg  <= 1'b1;
            out_kind_reg   <= rd_data_reg.kind;
            out_handle_reg <= rd_data_reg.handle;
            out_status_reg <= ST_OK;
            out_last_reg   <= (remain_reg == CNT_W'(1));
            out_fill_reg   <= count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_found  = out_found_reg;
    assign out_kind   = out_kind_reg;
    assign out_handle = out_handle_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;
    assign out_fill   = out_fill_reg;

endmodule

/* tb/job_queue_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_queue_checker
// keeps a shadow copy of the held jobs, works out every result word from the
// words taken on the input channel and compares the output channel against it
// ----------------------------------------------------------------------------
module job_queue_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // job_kind[2:0], job_handle[18:3], zero pad
    input  logic [2:0]  s_axis_tuser,   // action[2:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // out_kind[2:0], out_handle[18:3], fill_level[25:19]
    input  logic [2:0]  m_axis_tuser,   // found[0], status[2:1]
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending,
    output int          words_out,
    output int          full_refusals
);
    import cpjq_pkg::*;

    typedef struct packed {
        logic                   found;
        logic [KIND_W-1:0]      kind;
        logic [HANDLE_BITS-1:0] handle;
        logic [STATUS_W-1:0]    status;
        logic                   last;
        logic [CNT_W-1:0]       fill;
    } outcome_t;

    entry_t   held[$];
    outcome_t due[$];

    function automatic int oldest_of(logic [KIND_W-1:0] kind);
        foreach (held[i])
            if (held[i].kind == kind)
                return i;
        return -1;
    endfunction

    function automatic int mismatch(string field, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 0;
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        return 1;
    endfunction

    // applies one action to the shadow queue and appends the words it yields
    function automatic void queue_outcome(logic [ACTION_W-1:0] act, entry_t item);
        outcome_t          batch[$];
        outcome_t          r;
        logic [KIND_W-1:0] drained;
        int                pos;
        int                i;
        bit                single;
        r      = '0;
        r.last = 1'b1;
        pos    = -1;
        single = 1'b0;
        case (act)
            ACT_PUSH:
            begin
                if (held.size() >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                    held.push_back(item);
                batch.push_back(r);
            end
            ACT_POP:
            begin
                for (int k = 0; k < NUM_CLASSES && pos < 0; k++)
                    pos = oldest_of(KIND_W'(k));
                // nothing in the ranked kinds: fall back to the oldest job
                if (pos < 0 && held.size() > 0)
                    pos = 0;
                single = 1'b1;
            end
            ACT_DROP4:
            begin
                pos    = oldest_of(KIND_UPSERT);
                single = 1'b1;
            end
            ACT_DRAIN4, ACT_DRAIN1:
            begin
                drained = (act == ACT_DRAIN4) ? KIND_UPSERT : KIND_MATCH;
                i = 0;
                while (i < held.size())
                begin
                    if (held[i].kind == drained)
                    begin
                        r.found  = 1'b1;
                        r.kind   = held[i].kind;
                        r.handle = held[i].handle;
                        r.status = ST_OK;
                        r.last   = 1'b0;
                        batch.push_back(r);
                        held.delete(i);
                    end
                    else
                        i++;
                end
                if (batch.size() == 0)
                begin
                    r.status = ST_NONE;
                    batch.push_back(r);
                end
                else
                    batch[batch.size()-1].last = 1'b1;
            end
            default:
            begin
                r.status = ST_NONE;
                batch.push_back(r);
            end
        endcase
        if (single)
        begin
            if (pos < 0)
                r.status = ST_NONE;
            else
            begin
                r.found  = 1'b1;
                r.kind   = held[pos].kind;
                r.handle = held[pos].handle;
                held.delete(pos);
            end
            batch.push_back(r);
        end
        // every word of one action reports the fill after the whole action
        foreach (batch[j])
        begin
            batch[j].fill = CNT_W'(held.size());
            due.push_back(batch[j]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        entry_t   item;
        int       errs;
        if (!rst_n)
        begin
            held.delete();
            due.delete();
            fail_count    <= 0;
            pending       <= 0;
            words_out     <= 0;
            full_refusals <= 0;
        end
        else
        begin
            errs = 0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                item.kind   = s_axis_tdata[2:0];
                item.handle = s_axis_tdata[18:3];
                if (s_axis_tuser == ACT_PUSH && held.size() >= QUEUE_DEPTH)
                    full_refusals <= full_refusals + 1;
                queue_outcome(s_axis_tuser, item);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.found  = m_axis_tuser[0];
                got.status = m_axis_tuser[2:1];
                got.kind   = m_axis_tdata[2:0];
                got.handle = m_axis_tdata[18:3];
                got.fill   = m_axis_tdata[25:19];
                got.last   = m_axis_tlast;
                words_out <= words_out + 1;
                if (due.size() == 0)
                begin
                    $error("result word arrived with nothing expected");
                    errs++;
                end
                else
                begin
                    want = due.pop_front();
                    errs += mismatch("found", 32'(want.found), 32'(got.found));
                    errs += mismatch("out_kind", 32'(want.kind), 32'(got.kind));
                    errs += mismatch("out_handle", 32'(want.handle), 32'(got.handle));
                    errs += mismatch("status", 32'(want.status), 32'(got.status));
                    errs += mismatch("last", 32'(want.last), 32'(got.last));
                    errs += mismatch("fill_level", 32'(want.fill), 32'(got.fill));
                end
            end
            fail_count <= fail_count + errs;
            pending    <= due.size();
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives job words into the class priority job queue with random gaps and
// output stalls: directed corner cases, random mixes, a fill to overflow and
// a flood of one kind drained at once; the checker judges every result word
// ----------------------------------------------------------------------------
module tb;
    import cpjq_pkg::*;

    localparam int ITEMS       = 220;
    localparam int TAIL_CYCLES = 200;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    // actions the block does not define; each still answers with one word
    localparam logic [ACTION_W-1:0] ACT_RSVD5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;

    localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INGEST = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OTHER5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_OTHER6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_OTHER7 = 3'd7;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int words_out;
    int full_refusals;
    int act_seen[8];
    int sent;
    int tx_run;
    int rx_run;
    int cycles;

    class_priority_job_queue u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    job_queue_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_out     (words_out),
        .full_refusals (full_refusals)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle cycles before the next word; now and then a run with no idling
    function automatic int pick_wait(inout int run);
        if (run > 0)
        begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0)
            run = $urandom_range(8, 30);
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [KIND_W-1:0] random_kind();
        int pick;
        pick = $urandom_range(0, 9);
        // lean toward the kinds that drop and drain go after
        if (pick == 8)
            return KIND_MATCH;
        if (pick == 9)
            return KIND_UPSERT;
        return KIND_W'(pick);
    endfunction

    function automatic logic [HANDLE_BITS-1:0] random_handle();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return HANDLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [ACTION_W-1:0] act,
                             input logic [KIND_W-1:0] kind,
                             input logic [HANDLE_BITS-1:0] hnd);
        int gap;
        gap = pick_wait(tx_run);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {5'd0, hnd, kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        act_seen[act]++;
        sent++;
    endtask

    task automatic send_random();
        int pick;
        logic [ACTION_W-1:0] act;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            act = ACT_PUSH;
        else if (pick < 65)
            act = ACT_POP;
        else if (pick < 75)
            act = ACT_DROP4;
        else if (pick < 84)
            act = ACT_DRAIN4;
        else if (pick < 93)
            act = ACT_DRAIN1;
        else
            act = ACTION_W'($urandom_range(5, 7));
        send_word(act, random_kind(), random_handle());
    endtask

    // receiver: random stalls, plus one long hold-off to back the block up
    initial
    begin
        int  gap;
        int  hold;
        bit  held_off;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = pick_wait(rx_run);
            if (!held_off && words_out >= 40)
            begin
                held_off = 1'b1;
                gap      = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                for (hold = 0; hold < gap; hold++)
                    @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d result words still expected", cycles, pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        bit filled;
        bit flooded;
        filled  = 1'b0;
        flooded = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // everything on an empty queue
        send_word(ACT_POP, KIND_OPEN, '0);
        send_word(ACT_DROP4, KIND_OPEN, '0);
        send_word(ACT_DRAIN4, KIND_OPEN, '0);
        send_word(ACT_DRAIN1, KIND_OPEN, '0);
        send_word(ACT_RSVD5, KIND_OTHER7, '1);
        send_word(ACT_RSVD6, KIND_UPSERT, 16'h5555);
        send_word(ACT_RSVD7, KIND_MATCH, 16'hAAAA);

        // one of every kind, extreme handles
        send_word(ACT_PUSH, KIND_OPEN, 16'h0000);
        send_word(ACT_PUSH, KIND_OTHER7, 16'hFFFF);
        send_word(ACT_PUSH, KIND_UPSERT, 16'h1234);
        send_word(ACT_PUSH, KIND_MATCH, 16'hAAAA);
        send_word(ACT_PUSH, KIND_UPSERT, 16'h5555);
        send_word(ACT_PUSH, KIND_MATCH, 16'h8001);
        send_word(ACT_PUSH, KIND_OTHER6, 16'h7FFE);
        send_word(ACT_PUSH, KIND_INGEST, 16'h0F0F);
        send_word(ACT_PUSH, KIND_REMOVE, 16'hF0F0);
        send_word(ACT_PUSH, KIND_OTHER5, 16'h00FF);
        send_word(ACT_PUSH, KIND_UPSERT, 16'hC3C3);

        // priority order, drop, multi-word drain, and the fallback pop
        send_word(ACT_POP, KIND_OPEN, '0);
        send_word(ACT_DROP4, KIND_OPEN, '0);
        send_word(ACT_POP, KIND_OPEN, '0);
        send_word(ACT_DRAIN4, KIND_OPEN, '0);
        send_word(ACT_DRAIN1, KIND_OPEN, '0);
        send_word(ACT_POP, KIND_OPEN, '0);
        send_word(ACT_POP, KIND_OPEN, '0);
        send_word(ACT_POP, KIND_OPEN, '0);
        send_word(ACT_POP, KIND_OPEN, '0);

        while (sent < ITEMS)
        begin
            if (!filled && sent >= 60)
            begin
                // push past full, then drain kinds 4 and 1 and pop six jobs
                filled = 1'b1;
                repeat (QUEUE_DEPTH + 4)
                    send_word(ACT_PUSH, random_kind(), random_handle());
                send_word(ACT_DRAIN4, random_kind(), random_handle());
                send_word(ACT_DRAIN1, random_kind(), random_handle());
                repeat (6)
                    send_word(ACT_POP, random_kind(), random_handle());
            end
            else if (!flooded && sent >= 150)
            begin
                // push a queue depth of upserts, then remove them with a single drain
                flooded = 1'b1;
                repeat (QUEUE_DEPTH)
                    send_word(ACT_PUSH, KIND_UPSERT, random_handle());
                send_word(ACT_DRAIN4, random_kind(), random_handle());
            end
            else
                send_random();
        end
        s_axis_tvalid <= 1'b0;

        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending != 0)
            $error("%0d expected result words never arrived", pending);

        $display("covered %0d input words: %0d push, %0d pop, %0d drop, %0d drain, %0d reserved",
                 sent, act_seen[ACT_PUSH], act_seen[ACT_POP], act_seen[ACT_DROP4],
                 act_seen[ACT_DRAIN4] + act_seen[ACT_DRAIN1],
                 act_seen[ACT_RSVD5] + act_seen[ACT_RSVD6] + act_seen[ACT_RSVD7]);
        $display("checked %0d result words, %0d pushes refused on a full queue, %0d mismatches",
                 words_out, full_refusals, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
